>>> hw/rtl/brp_pkg.sv
// shared types, constants and helpers for the byte range parser
`default_nettype none

package brp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 63;
  localparam int unsigned LAST_W = 64;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_FIRST,
    PH_SECOND
  } parse_phase_t;

  // one finished header, handed from the parser to the evaluator
  typedef struct packed {
    logic              bad;
    logic              in_second;
    logic              suffix;
    logic              first_has;
    logic              second_has;
    logic [LEN_W-1:0]  first_num;
    logic [LEN_W-1:0]  second_num;
    logic [LEN_W-1:0]  file_length;
  } brp_req_t;

  // expected character of "bytes=" at each position
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] ch;
    case (pos)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/brp_front.sv
// byte parser: walks the prefix, accumulates both numbers, emits a request per header
`default_nettype none

module brp_front import brp_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 63
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] header_byte,
  input  wire logic              final_byte,
  input  wire logic [LEN_W-1:0]  file_length,
  output logic                   req_push,
  output brp_req_t               req
);

  localparam int unsigned W = OFFSET_BITS;

  parse_phase_t   phase_r, phase_nxt, phase_upd;
  logic [2:0]     pos_r, pos_nxt, pos_upd;
  logic [W-1:0]   first_r, first_nxt, first_upd;
  logic [W-1:0]   second_r, second_nxt, second_upd;
  logic           fhas_r, fhas_nxt, fhas_upd;
  logic           shas_r, shas_nxt, shas_upd;
  logic           suffix_r, suffix_nxt, suffix_upd;
  logic           bad_r, bad_nxt, bad_upd;

  logic           is_digit;
  logic [3:0]     digit_val;
  logic [W-1:0]   acc_in;
  logic [W+3:0]   acc_full;
  logic [W-1:0]   acc_out;

  assign is_digit  = (header_byte >= CHAR_ZERO) && (header_byte <= CHAR_NINE);
  assign digit_val = 4'(header_byte - CHAR_ZERO);

  // times ten plus digit, saturating at all ones
  assign acc_in   = (phase_r == PH_FIRST) ? first_r : second_r;
  assign acc_full = ((W+4)'(acc_in) << 3) + ((W+4)'(acc_in) << 1) + (W+4)'(digit_val);
  assign acc_out  = (acc_full[W+3:W] != 4'd0) ? {W{1'b1}} : acc_full[W-1:0];

  always_comb begin
    phase_upd  = phase_r;
    pos_upd    = pos_r;
    first_upd  = first_r;
    second_upd = second_r;
    fhas_upd   = fhas_r;
    shas_upd   = shas_r;
    suffix_upd = suffix_r;
    bad_upd    = bad_r;
    case (phase_r)
      PH_PREFIX: begin
        if (header_byte != prefix_char(pos_r)) begin
          bad_upd = 1'b1;
        end
        pos_upd = pos_r + 3'd1;
        if (pos_upd >= PREFIX_LEN) begin
          phase_upd = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (is_digit) begin
          first_upd = acc_out;
          fhas_upd  = 1'b1;
        end else if (header_byte == CHAR_DASH) begin
          if (!fhas_r) begin
            suffix_upd = 1'b1;
          end
          phase_upd = PH_SECOND;
        end else begin
          bad_upd = 1'b1;
        end
      end
      PH_SECOND: begin
        if (is_digit) begin
          second_upd = acc_out;
          shas_upd   = 1'b1;
        end else begin
          bad_upd = 1'b1;
        end
      end
      default: begin
        bad_upd = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    fhas_nxt   = fhas_r;
    shas_nxt   = shas_r;
    suffix_nxt = suffix_r;
    bad_nxt    = bad_r;
    if (take) begin
      if (final_byte) begin
        phase_nxt  = PH_PREFIX;
        pos_nxt    = 3'd0;
        first_nxt  = '0;
        second_nxt = '0;
        fhas_nxt   = 1'b0;
        shas_nxt   = 1'b0;
        suffix_nxt = 1'b0;
        bad_nxt    = 1'b0;
      end else begin
        phase_nxt  = phase_upd;
        pos_nxt    = pos_upd;
        first_nxt  = first_upd;
        second_nxt = second_upd;
        fhas_nxt   = fhas_upd;
        shas_nxt   = shas_upd;
        suffix_nxt = suffix_upd;
        bad_nxt    = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      pos_r    <= 3'd0;
      first_r  <= '0;
      second_r <= '0;
      fhas_r   <= 1'b0;
      shas_r   <= 1'b0;
      suffix_r <= 1'b0;
      bad_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      fhas_r   <= fhas_nxt;
      shas_r   <= shas_nxt;
      suffix_r <= suffix_nxt;
      bad_r    <= bad_nxt;
    end
  end

  assign req_push        = take && final_byte;
  assign req.bad         = bad_upd;
  assign req.in_second   = (phase_upd == PH_SECOND);
  assign req.suffix      = suffix_upd;
  assign req.first_has   = fhas_upd;
  assign req.second_has  = shas_upd;
  assign req.first_num   = LEN_W'(first_upd);
  assign req.second_num  = LEN_W'(second_upd);
  assign req.file_length = file_length;

endmodule

`default_nettype wire

>>> hw/rtl/brp_queue.sv
// two-entry request queue between the parser and the evaluator
`default_nettype none

module brp_queue import brp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire brp_req_t wr_data,
  output logic          full,
  input  wire logic     rd_en,
  output logic          not_empty,
  output brp_req_t      rd_data
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  brp_req_t              mem [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]        count_r, count_nxt;

  assign full      = (count_r == (PTR_W+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/brp_back.sv
// range evaluator: checks a finished header against the file length, holds the result
`default_nettype none

module brp_back import brp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                req_avail,
  input  wire brp_req_t            req,
  output logic                     req_take,
  input  wire logic                pop,
  output logic                     empty,
  output logic                     range_valid,
  output logic [LEN_W-1:0]         range_first,
  output logic signed [LAST_W-1:0] range_last
);

  logic                     valid_r;
  logic                     ok_r, ok_nxt;
  logic [LEN_W-1:0]         first_r, first_nxt;
  logic [LAST_W-1:0]        last_r, last_nxt;

  logic [LAST_W-1:0]        len_ext;
  logic [LAST_W-1:0]        sfx_diff;
  logic [LAST_W-1:0]        end_off;
  logic                     first_lt_len;
  logic                     second_ge_first;
  logic                     second_ge_len;

  assign len_ext  = LAST_W'(req.file_length);
  // borrow out of len - n means the suffix covers the whole file
  assign sfx_diff = len_ext - LAST_W'(req.second_num);
  // wraps to all ones on an empty file
  assign end_off  = len_ext - LAST_W'(1);

  assign first_lt_len    = req.first_num < req.file_length;
  assign second_ge_first = req.second_num >= req.first_num;
  assign second_ge_len   = req.second_num >= req.file_length;

  always_comb begin
    ok_nxt    = 1'b0;
    first_nxt = '0;
    last_nxt  = '0;
    if (!req.bad && req.in_second) begin
      if (req.suffix) begin
        if (req.second_has && (req.second_num != '0)) begin
          ok_nxt    = 1'b1;
          first_nxt = sfx_diff[LAST_W-1] ? '0 : sfx_diff[LEN_W-1:0];
          last_nxt  = end_off;
        end
      end else if (req.first_has && first_lt_len) begin
        if (!req.second_has) begin
          ok_nxt    = 1'b1;
          first_nxt = req.first_num;
          last_nxt  = end_off;
        end else if (second_ge_first) begin
          ok_nxt    = 1'b1;
          first_nxt = req.first_num;
          last_nxt  = second_ge_len ? end_off : LAST_W'(req.second_num);
        end
      end
    end
  end

  // refill the output register whenever it is free or being popped
  assign req_take = req_avail && (!valid_r || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_take) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      ok_r    <= ok_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  assign empty       = !valid_r;
  assign range_valid = ok_r;
  assign range_first = first_r;
  assign range_last  = $signed(last_r);

endmodule

`default_nettype wire

>>> hw/rtl/http_byte_range_parser.sv
// top level of the streaming single-range header parser
`default_nettype none

// Takes the value of an HTTP Range header one byte per cycle and, for every
// byte marked final, gives one result: valid flag and inclusive first and last
// byte offsets of a "bytes=" single range against file_length (sampled with
// the final byte). A new byte can be taken every cycle that in_full is low;
// the parser keeps the running state and hands each finished header to a
// two-entry queue, from which the evaluator fills the output register. The
// output register is refilled in the same cycle it is popped if the queue
// holds a header, so one result per cycle drains. in_full rises only while
// the queue holds two finished headers the result side has not yet taken.
// OFFSET_BITS sets where the parsed numbers saturate.
module http_byte_range_parser import brp_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 63
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic [BYTE_W-1:0]   in_header_byte,
  input  wire logic                in_final_byte,
  input  wire logic [LEN_W-1:0]    in_file_length,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic                     out_range_valid,
  output logic [LEN_W-1:0]         out_range_first,
  output logic signed [LAST_W-1:0] out_range_last
);

  logic      take;
  logic      req_push;
  brp_req_t  req_in;
  brp_req_t  req_out;
  logic      q_full;
  logic      q_avail;
  logic      q_take;

  assign in_full = q_full;
  assign take    = in_push && !q_full;

  brp_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .header_byte (in_header_byte),
    .final_byte  (in_final_byte),
    .file_length (in_file_length),
    .req_push    (req_push),
    .req         (req_in)
  );

  brp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (req_push),
    .wr_data   (req_in),
    .full      (q_full),
    .rd_en     (q_take),
    .not_empty (q_avail),
    .rd_data   (req_out)
  );

  brp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_avail   (q_avail),
    .req         (req_out),
    .req_take    (q_take),
    .pop         (out_pop),
    .empty       (out_empty),
    .range_valid (out_range_valid),
    .range_first (out_range_first),
    .range_last  (out_range_last)
  );

  // a rejected header carries zero offsets
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_range_valid) |-> (out_range_first == '0 && out_range_last == '0))
    else $error("invalid result with nonzero offsets");

  // an accepted range never ends before it starts, except the empty-file suffix
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_range_valid && out_range_last != -64'sd1)
      |-> ($signed({1'b0, out_range_first}) <= out_range_last))
    else $error("valid range ends before its start");

  // a full queue means the output register was already loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("queue full while output register is idle");

  // nothing waits on the result side right after reset
  assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the streaming single-range header parser
`timescale 1ns / 1ps

module tb_top;
  import brp_pkg::*;

  localparam logic [63:0] NUM_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [47:0] PREFIX_TEXT = "bytes=";
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2c;
  localparam int RANDOM_BYTES = 280;

  typedef struct {
    logic                     valid;
    logic [LEN_W-1:0]         first;
    logic signed [LAST_W-1:0] last;
  } byte_range_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [BYTE_W-1:0]        in_header_byte = '0;
  logic                     in_final_byte = 1'b0;
  logic [LEN_W-1:0]         in_file_length = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic                     out_range_valid;
  logic [LEN_W-1:0]         out_range_first;
  logic signed [LAST_W-1:0] out_range_last;

  // parser state as the predictor sees it
  parse_phase_t phase;
  logic [2:0]   prefix_pos;
  logic [63:0]  first_num;
  logic [63:0]  second_num;
  logic         first_has;
  logic         second_has;
  logic         suffix_seen;
  logic         header_bad;

  byte_range_t       pending_ranges[$];
  byte_range_t       due;
  logic [BYTE_W-1:0] header_buf[$];
  int                bytes_sent = 0;
  int                ranges_checked = 0;
  int                valid_ranges = 0;
  int                mismatches = 0;
  int                pop_hold = 0;
  bit                steady_send = 1'b0;
  bit                steady_recv = 1'b0;

  http_byte_range_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_header_byte  (in_header_byte),
    .in_final_byte   (in_final_byte),
    .in_file_length  (in_file_length),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_range_valid (out_range_valid),
    .out_range_first (out_range_first),
    .out_range_last  (out_range_last)
  );

  always #5 clk = ~clk;

  function automatic void clear_parser();
    phase       = PH_PREFIX;
    prefix_pos  = '0;
    first_num   = '0;
    second_num  = '0;
    first_has   = 1'b0;
    second_has  = 1'b0;
    suffix_seen = 1'b0;
    header_bad  = 1'b0;
  endfunction

  // decimal accumulate that sticks at the top of the offset range
  function automatic logic [63:0] times_ten_plus(input logic [63:0] v, input logic [63:0] d);
    if (v > (NUM_MAX - d) / 10) return NUM_MAX;
    return v * 10 + d;
  endfunction

  // advance the parser by one accepted byte; a final byte yields one range
  function automatic void take_header_byte(input logic [BYTE_W-1:0] c, input logic fin,
                                           input logic [LEN_W-1:0] len);
    logic        is_digit;
    logic [63:0] d;
    logic [63:0] flen;
    logic [63:0] n;
    logic [63:0] lo;
    logic [63:0] hi;
    byte_range_t r;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = {56'd0, c} - {56'd0, CHAR_ZERO};
    case (phase)
      PH_PREFIX: begin
        if (c != PREFIX_TEXT[47 - 8 * int'(prefix_pos) -: 8]) header_bad = 1'b1;
        prefix_pos = prefix_pos + 3'd1;
        if (prefix_pos >= PREFIX_LEN) phase = PH_FIRST;
      end
      PH_FIRST: begin
        if (is_digit) begin
          first_num = times_ten_plus(first_num, d);
          first_has = 1'b1;
        end else if (c == CHAR_DASH) begin
          if (!first_has) suffix_seen = 1'b1;
          phase = PH_SECOND;
        end else begin
          header_bad = 1'b1;
        end
      end
      default: begin
        if (is_digit) begin
          second_num = times_ten_plus(second_num, d);
          second_has = 1'b1;
        end else begin
          header_bad = 1'b1;
        end
      end
    endcase
    if (fin) begin
      r.valid = 1'b0;
      lo = '0;
      hi = '0;
      flen = {1'b0, len};
      if (!header_bad && phase == PH_SECOND) begin
        if (suffix_seen) begin
          if (second_has && second_num > 0) begin
            n = (second_num > flen) ? flen : second_num;
            lo = flen - n;
            hi = flen - 64'd1;  // all ones on an empty file
            r.valid = 1'b1;
          end
        end else if (first_has && first_num < flen) begin
          if (!second_has) begin
            lo = first_num;
            hi = flen - 64'd1;
            r.valid = 1'b1;
          end else if (second_num >= first_num) begin
            lo = first_num;
            hi = (second_num >= flen) ? flen - 64'd1 : second_num;
            r.valid = 1'b1;
          end
        end
      end
      r.first = lo[LEN_W-1:0];
      r.last = hi;
      pending_ranges.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic logic [LEN_W-1:0] any_length();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[LEN_W-1:0];
  endfunction

  // one request: random hold-off, then push until the block takes it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                           input logic [LEN_W-1:0] len);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_header_byte = b;
    in_final_byte = fin;
    in_file_length = len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    take_header_byte(b, fin, len);
    bytes_sent++;
  endtask

  // sends the buffered header; only its last byte carries the file length
  task automatic send_header(input logic [63:0] flen);
    int last_idx;
    last_idx = header_buf.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (i == last_idx) send_byte(header_buf[i], 1'b1, flen[LEN_W-1:0]);
      else send_byte(header_buf[i], 1'b0, any_length());
    end
    header_buf.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) header_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s, input logic [63:0] flen);
    add_text(s);
    send_header(flen);
  endtask

  task automatic test_prefix();
    send_text("b", 64'd10);
    send_text("byte", 64'd10);
    send_text("bytes=", 64'd10);
    send_text("Bytes=0-1", 64'd10);
    send_text("bytes:0-1", 64'd10);
  endtask

  task automatic test_suffix_ranges();
    send_text("bytes=-5", 64'd100);
    send_text("bytes=-500", 64'd100);
    send_text("bytes=-1", 64'd0);
    send_text("bytes=-0", 64'd100);
    send_text("bytes=-", 64'd100);
  endtask

  task automatic test_start_ranges();
    send_text("bytes=0-0", 64'd1);
    send_text("bytes=10-", 64'd100);
    send_text("bytes=10-20", 64'd100);
    send_text("bytes=10-999", 64'd100);
    send_text("bytes=20-10", 64'd100);
    send_text("bytes=100-", 64'd100);
  endtask

  task automatic test_malformed();
    send_text("bytes=5", 64'd100);
    send_text("bytes=1-2-3", 64'd100);
    send_text("bytes=1-2,3-4", 64'd100);
    send_text("bytes=,1-2", 64'd100);
    send_text("bytes=1a-2", 64'd100);
    send_text("bytes= 1-2", 64'd100);
    send_text("bytes=+1-2", 64'd100);
    // a nul byte is as bad as any other non-digit
    add_text("bytes=1-");
    header_buf.push_back(8'h00);
    send_header(64'd100);
  endtask

  task automatic test_saturation();
    send_text("bytes=99999999999999999999-", NUM_MAX);
    send_text("bytes=9223372036854775806-", NUM_MAX);
    send_text("bytes=0-99999999999999999999", NUM_MAX);
    send_text("bytes=-99999999999999999999", NUM_MAX);
  endtask

  function automatic logic [63:0] pick_offset(input logic [63:0] flen);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0, 1, 2: return 64'($urandom_range(0, 2500));
      3:       return flen;
      4:       return (flen == 0) ? 64'd0 : flen - 64'd1;
      5:       return flen + 64'd1;
      6:       return w >> 1;
      default: return flen / 2;
    endcase
  endfunction

  function automatic string number_text(input logic [63:0] v);
    string s;
    case ($urandom_range(0, 9))
      0: s = {"0", $sformatf("%0d", v)};
      1: begin
        s = "";
        repeat ($urandom_range(19, 24)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      default: s = $sformatf("%0d", v);
    endcase
    return s;
  endfunction

  function automatic logic [63:0] pick_length();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return NUM_MAX;
      2, 3:    return w >> 1;
      default: return 64'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic void build_range_header(input logic [63:0] flen);
    logic [63:0] a;
    logic [63:0] b;
    a = pick_offset(flen);
    case ($urandom_range(0, 2))
      0: add_text({"bytes=-", number_text(a)});
      1: add_text({"bytes=", number_text(a), "-"});
      default: begin
        case ($urandom_range(0, 3))
          0:       b = a + 64'($urandom_range(0, 50));
          1:       b = (a == 0) ? a : a - 64'd1;
          2:       b = a;
          default: b = pick_offset(flen);
        endcase
        add_text({"bytes=", number_text(a), "-", number_text(b)});
      end
    endcase
  endfunction

  // mostly well-formed headers, some damaged, some pure noise
  task automatic test_random_headers();
    logic [63:0] flen;
    int          start_count;
    int          kind;
    int          pos;
    int          cut;
    int          hdr_count;
    start_count = bytes_sent;
    hdr_count = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (hdr_count % 8 == 0) begin
        steady_send = ($urandom_range(0, 3) == 0);
        steady_recv = ($urandom_range(0, 3) == 0);
      end
      flen = pick_length();
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        build_range_header(flen);
      end else if (kind < 17) begin
        build_range_header(flen);
        pos = $urandom_range(0, header_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: header_buf[pos] = 8'($urandom_range(0, 255));
          1: header_buf.insert(pos, CHAR_COMMA);
          2: header_buf.insert(pos, CHAR_DASH);
          default: begin
            cut = $urandom_range(1, header_buf.size());
            while (header_buf.size() > cut) void'(header_buf.pop_back());
          end
        endcase
      end else begin
        if ($urandom_range(0, 1) == 1) add_text("bytes=");
        repeat ($urandom_range(1, 8)) header_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_header(flen);
      hdr_count++;
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
  endtask

  // result side: random stall before each pop, checked at the rising edge
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= rst_n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_ranges.size() == 0) begin
        $error("range result with none expected: valid %0d first %0d last %0d",
               out_range_valid, out_range_first, out_range_last);
        mismatches++;
      end else begin
        due = pending_ranges.pop_front();
        if (out_range_valid !== due.valid) begin
          $error("range_valid: expected %0d, got %0d", due.valid, out_range_valid);
          mismatches++;
        end
        if (out_range_first !== due.first) begin
          $error("range_first: expected %0d, got %0d", due.first, out_range_first);
          mismatches++;
        end
        if (out_range_last !== due.last) begin
          $error("range_last: expected %0d, got %0d", due.last, out_range_last);
          mismatches++;
        end
        ranges_checked++;
        if (due.valid) valid_ranges++;
      end
      pop_hold <= steady_recv ? 0 : $urandom_range(0, 11);
    end
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_prefix();
    test_suffix_ranges();
    test_start_ranges();
    test_malformed();
    test_saturation();
    test_random_headers();
    @(negedge clk);
    in_push = 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d header bytes sent, %0d range results checked, %0d of them satisfiable",
             bytes_sent, ranges_checked, valid_ranges);
    if (mismatches == 0) begin
      $display("** http_byte_range_parser: PASSED **");
    end else begin
      $display("** http_byte_range_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d range results outstanding", pending_ranges.size());
    $display("** http_byte_range_parser: FAILED **");
    $finish;
  end

endmodule

>>> http_byte_range_parser.f
hw/rtl/brp_pkg.sv
hw/rtl/brp_front.sv
hw/rtl/brp_queue.sv
hw/rtl/brp_back.sv
hw/rtl/http_byte_range_parser.sv
tb/sv/tb_top.sv
